// ----- rtl/rnh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnh_pkg
// Shared types and constants of the nearest-hit ray intersection core.
// ----------------------------------------------------------------------------
package rnh_pkg;

    localparam int THR_W = 16;
    localparam int IDX_W = 8;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_SPHERE = 2'd1,
        ACT_PLANE  = 2'd2,
        ACT_DISK   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_SQRT,
        ST_DIV,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        PH_S_L,
        PH_S_HH,
        PH_S_LT,
        PH_S_R2,
        PH_S_ROOT,
        PH_P_DP,
        PH_P_NN,
        PH_P_NLEN,
        PH_P_THR,
        PH_P_NUM,
        PH_P_DIV,
        PH_D_V0,
        PH_D_V1,
        PH_D_V2,
        PH_D_SQ,
        PH_D_R2
    } phase_t;

endpackage

// ----- rtl/ray_nearest_hit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_nearest_hit_core
// Closest-hit ray test engine for spheres, planes and disks, fixed point.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall, one at a time; in_stall stays high
// while a request is in work. A start-ray request loads origin and direction
// and clears the nearest hit; each later request tests one primitive.
// Every request gives one result on out_valid/out_stall from an output
// register; a held result keeps its payload until taken.
// Each dot product runs on the shared multiplier. The root and the divider
// each take one bit per cycle. The next request can be taken in the cycle
// after the result is loaded.
// The threshold register is written on cfg_valid/cfg_ready (always ready).
// Reset clears the ray to zero, the nearest hit to none and the index to 0.
// A stalled receiver holds the engine in its final step until the output
// register frees.
// ----------------------------------------------------------------------------
module ray_nearest_hit_core import rnh_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OBJECTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    input  logic [COORD_WIDTH-2:0]        radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit_this,
    output logic [COORD_WIDTH-1:0]        nearest_distance,
    output logic [IDX_W-1:0]              nearest_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [THR_W-1:0]              cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW + 3;
    localparam int PW    = 2 * MW;
    localparam int ACC_W = PW + 2;
    localparam int RW    = ACC_W + 1;
    localparam int VW    = ACC_W + 1;
    localparam int NW    = ACC_W + FRAC_BITS;
    localparam int CNT_W = $clog2(CW);
    localparam int OBJ_W = $clog2(MAX_OBJECTS);

    localparam logic [CW-1:0]           NO_HIT   = '1;
    localparam logic [CW+1:0]           NO_HIT_X = {2'b00, NO_HIT};
    localparam logic signed [ACC_W-1:0] LT_MAX   = ACC_W'(1) << (CW + 1);
    localparam logic [VW-1:0]           AV_MAX   = VW'(1) << CW;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    action_t                 act_reg;
    logic signed [CW-1:0]    org_reg [3];
    logic signed [CW-1:0]    dir_reg [3];
    logic signed [CW-1:0]    vec_reg [3];
    logic signed [CW:0]      h_reg [3];
    logic [CW-2:0]           rad_reg;
    logic [THR_W-1:0]        thr_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PW-1:0]    prod_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CW+1:0]           lt_reg;
    logic signed [ACC_W-1:0] hh_reg;
    logic signed [ACC_W-1:0] dp_reg;
    logic [CW-1:0]           t_reg;
    logic [RW-1:0]           div_rem_reg;
    logic [CW-1:0]           n_lo_reg;
    logic [CW-1:0]           q_reg;
    logic [CW:0]             av_reg [3];
    logic [CW-1:0]           nearest_reg;
    logic [OBJ_W-1:0]        nobj_reg;
    logic [OBJ_W-1:0]        count_reg;
    logic                    out_valid_reg;
    logic                    hit_reg;
    logic [CW-1:0]           dist_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic                    in_accept;
    logic                    fin_load;
    logic                    fin_hit;
    logic [OBJ_W+IDX_W-1:0]  idx_wide;
    logic                    step_miss;
    logic                    step_done;
    phase_t                  step_phase;
    state_t                  step_unit;
    logic signed [MW-1:0]    opa [3];
    logic signed [MW-1:0]    opb [3];
    logic [1:0]              k_sel;
    logic [1:0]              axis;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [ACC_W-1:0] sq_diff;
    logic [2*CW-1:0]         sq_in;
    logic                    sq_start;
    logic                    sq_done;
    logic [CW-1:0]           sq_root;
    logic [CW+1:0]           lx;
    logic [CW+1:0]           ts;
    logic [NW-1:0]           nsh;
    logic [NW-1:0]           nsh_hi;
    logic [RW-1:0]           r0;
    logic [RW-1:0]           dpu;
    logic [RW-1:0]           r_sh;
    logic                    div_ge;
    logic signed [VW-1:0]    v_sum;
    logic [VW-1:0]           v_abs;

    rnh_sqrt #(
        .ROOT_W (CW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign in_accept = in_valid && !in_stall;
    assign fin_load  = (state_reg == ST_FINISH) && !(out_valid_reg && out_stall);
    assign fin_hit   = t_reg < nearest_reg;
    assign idx_wide  = {IDX_W'(0), fin_hit ? count_reg : nobj_reg};

    assign acc_sh  = acc_reg >>> FRAC_BITS;
    assign sq_diff = acc_reg - hh_reg;
    assign sq_in   = (phase_reg == PH_S_R2) ? sq_diff[2*CW-1:0] : acc_reg[2*CW-1:0];
    assign lx      = (CW + 2)'(sq_root);
    assign ts      = (lt_reg >= lx) ? lt_reg - lx : lt_reg + lx;
    assign nsh     = {acc_reg, {FRAC_BITS{1'b0}}};
    assign nsh_hi  = nsh >> CW;
    assign r0      = nsh_hi[RW-1:0];
    assign dpu     = {1'b0, dp_reg};
    assign r_sh    = {div_rem_reg[RW-2:0], n_lo_reg[CW-1]};
    assign div_ge  = r_sh >= dpu;
    assign v_sum   = VW'(acc_sh) - VW'(h_reg[axis]);
    assign v_abs   = v_sum[VW-1] ? VW'(-v_sum) : VW'(v_sum);
    assign k_sel   = (cnt_reg < CNT_W'(3)) ? cnt_reg[1:0] : 2'd0;

    always_comb
    begin
        case (phase_reg)
            PH_D_V1: axis = 2'd1;
            PH_D_V2: axis = 2'd2;
            default: axis = 2'd0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            opa[i] = '0;
            opb[i] = '0;
        end
        case (phase_reg)
            PH_S_L:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(h_reg[i]);
                    opb[i] = MW'(dir_reg[i]);
                end
            end
            PH_S_HH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(h_reg[i]);
                    opb[i] = MW'(h_reg[i]);
                end
            end
            PH_S_LT:
            begin
                opa[0] = MW'(lt_reg);
                opb[0] = MW'(lt_reg);
            end
            PH_S_R2, PH_D_R2:
            begin
                opa[0] = MW'(rad_reg);
                opb[0] = MW'(rad_reg);
            end
            PH_P_DP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(dir_reg[i]);
                    opb[i] = MW'(vec_reg[i]);
                end
            end
            PH_P_NN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(vec_reg[i]);
                    opb[i] = MW'(vec_reg[i]);
                end
            end
            PH_P_THR:
            begin
                opa[0] = MW'(thr_reg);
                opb[0] = MW'(sq_root);
            end
            PH_P_NUM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(h_reg[i]);
                    opb[i] = MW'(vec_reg[i]);
                end
            end
            PH_D_V0, PH_D_V1, PH_D_V2:
            begin
                opa[0] = MW'(dir_reg[axis]);
                opb[0] = MW'(t_reg);
            end
            PH_D_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    opa[i] = MW'(av_reg[i]);
                    opb[i] = MW'(av_reg[i]);
                end
            end
            default:
            begin
                opa[0] = '0;
            end
        endcase
    end

    // decide the next step after a unit finishes
    always_comb
    begin
        step_miss  = 1'b0;
        step_done  = 1'b0;
        step_phase = phase_reg;
        step_unit  = ST_DOT;
        case (phase_reg)
            PH_S_L:
                if (acc_reg[ACC_W-1] || (acc_sh > LT_MAX)) step_miss = 1'b1;
                else step_phase = PH_S_HH;
            PH_S_HH:  step_phase = PH_S_LT;
            PH_S_LT:  step_phase = PH_S_R2;
            PH_S_R2:
                if (hh_reg[ACC_W-1] || (hh_reg > acc_reg)) step_miss = 1'b1;
                else
                begin
                    step_phase = PH_S_ROOT;
                    step_unit  = ST_SQRT;
                end
            PH_S_ROOT:
                if (ts >= NO_HIT_X) step_miss = 1'b1;
                else step_done = 1'b1;
            PH_P_DP:  step_phase = PH_P_NN;
            PH_P_NN:
            begin
                step_phase = PH_P_NLEN;
                step_unit  = ST_SQRT;
            end
            PH_P_NLEN: step_phase = PH_P_THR;
            PH_P_THR:
                if (!(dp_reg > acc_reg)) step_miss = 1'b1;
                else step_phase = PH_P_NUM;
            PH_P_NUM:
                if (acc_reg[ACC_W-1] || (r0 >= dpu)) step_miss = 1'b1;
                else
                begin
                    step_phase = PH_P_DIV;
                    step_unit  = ST_DIV;
                end
            PH_P_DIV:
                if (q_reg == NO_HIT) step_miss = 1'b1;
                else if (act_reg == ACT_DISK) step_phase = PH_D_V0;
                else step_done = 1'b1;
            PH_D_V0:
                if (v_abs > AV_MAX) step_miss = 1'b1;
                else step_phase = PH_D_V1;
            PH_D_V1:
                if (v_abs > AV_MAX) step_miss = 1'b1;
                else step_phase = PH_D_V2;
            PH_D_V2:
                if (v_abs > AV_MAX) step_miss = 1'b1;
                else step_phase = PH_D_SQ;
            PH_D_SQ:  step_phase = PH_D_R2;
            PH_D_R2:
                if (hh_reg > acc_reg) step_miss = 1'b1;
                else step_done = 1'b1;
            default:  step_miss = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
                if (in_accept)
                begin
                    if (action_t'(action) == ACT_START) state_next = ST_FINISH;
                    else state_next = ST_DOT;
                    phase_next = (action_t'(action) == ACT_SPHERE) ? PH_S_L : PH_P_DP;
                end
            ST_DOT:
                if (cnt_reg == CNT_W'(3)) state_next = ST_STEP;
            ST_SQRT:
                if (sq_done) state_next = ST_STEP;
            ST_DIV:
                if (cnt_reg == CNT_W'(CW - 1)) state_next = ST_STEP;
            ST_STEP:
                if (step_miss || step_done) state_next = ST_FINISH;
                else
                begin
                    state_next = step_unit;
                    phase_next = step_phase;
                end
            ST_FINISH:
                if (fin_load) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        cfg_ready = 1'b1;
        sq_start = (state_reg == ST_STEP) && !step_miss && !step_done
                   && (step_unit == ST_SQRT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_S_L;
            thr_reg       <= '0;
            nearest_reg   <= NO_HIT;
            nobj_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready) thr_reg <= cfg_data;
            if (in_accept && (action_t'(action) == ACT_START))
            begin
                org_reg[0]  <= pos_x;
                org_reg[1]  <= pos_y;
                org_reg[2]  <= pos_z;
                dir_reg[0]  <= vec_x;
                dir_reg[1]  <= vec_y;
                dir_reg[2]  <= vec_z;
                nearest_reg <= NO_HIT;
                nobj_reg    <= '0;
                count_reg   <= '0;
            end
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
                if (fin_hit)
                begin
                    nearest_reg <= t_reg;
                    nobj_reg    <= count_reg;
                end
                if (act_reg != ACT_START)
                begin
                    if (count_reg == OBJ_W'(MAX_OBJECTS - 1)) count_reg <= '0;
                    else count_reg <= count_reg + OBJ_W'(1);
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg    <= action_t'(action);
            vec_reg[0] <= vec_x;
            vec_reg[1] <= vec_y;
            vec_reg[2] <= vec_z;
            h_reg[0]   <= (CW + 1)'(pos_x) - (CW + 1)'(org_reg[0]);
            h_reg[1]   <= (CW + 1)'(pos_y) - (CW + 1)'(org_reg[1]);
            h_reg[2]   <= (CW + 1)'(pos_z) - (CW + 1)'(org_reg[2]);
            rad_reg    <= radius;
            t_reg      <= NO_HIT;
        end

        if ((state_reg != ST_DOT) && (state_next == ST_DOT))
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == ST_DOT)
        begin
            if (cnt_reg < CNT_W'(3)) prod_reg <= opa[k_sel] * opb[k_sel];
            if (cnt_reg != '0) acc_reg <= acc_reg + ACC_W'(prod_reg);
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if ((state_reg == ST_STEP) && (phase_reg == PH_P_NUM) && !step_miss)
        begin
            div_rem_reg <= r0;
            n_lo_reg    <= nsh[CW-1:0];
            q_reg       <= '0;
            cnt_reg     <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            div_rem_reg <= div_ge ? r_sh - dpu : r_sh;
            n_lo_reg    <= {n_lo_reg[CW-2:0], 1'b0};
            q_reg       <= {q_reg[CW-2:0], div_ge};
            cnt_reg     <= cnt_reg + CNT_W'(1);
        end

        if (state_reg == ST_STEP)
        begin
            case (phase_reg)
                PH_S_L:  lt_reg <= acc_sh[CW+1:0];
                PH_S_HH: hh_reg <= acc_reg;
                PH_S_LT: hh_reg <= hh_reg - acc_reg;
                PH_P_DP: dp_reg <= acc_reg;
                PH_D_V0, PH_D_V1, PH_D_V2: av_reg[axis] <= v_abs[CW:0];
                PH_D_SQ: hh_reg <= acc_reg;
                default: hh_reg <= hh_reg;
            endcase
            if (step_miss) t_reg <= NO_HIT;
            else if (phase_reg == PH_S_ROOT) t_reg <= ts[CW-1:0];
            else if (phase_reg == PH_P_DIV) t_reg <= q_reg;
        end

        if (fin_load)
        begin
            hit_reg  <= fin_hit;
            dist_reg <= fin_hit ? t_reg : nearest_reg;
            idx_reg  <= idx_wide[IDX_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit_this         = hit_reg;
    assign nearest_distance = dist_reg;
    assign nearest_index    = idx_reg;

    a_hit_has_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit_this) |-> (nearest_distance != NO_HIT))
        else $error("hit reported without a distance");

    a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dp_reg > 0))
        else $error("divide with nonpositive divisor");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == ST_SQRT))
        else $error("root finished outside of its wait state");

    a_prim_starts_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (action_t'(action) != ACT_START)) |=> (state_reg == ST_DOT))
        else $error("primitive request did not start a dot product");

endmodule

// ----- rtl/rnh_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnh_sqrt
// Restoring integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rnh_sqrt #(
    parameter int ROOT_W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [2*ROOT_W-1:0]   x_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [ROOT_W+1:0]     rem_sh;
    logic [ROOT_W+1:0]     trial;
    logic                  ge;

    assign rem_sh = {rem_reg[ROOT_W-1:0], x_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[2*ROOT_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- tb/sv/ray_nearest_hit_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_nearest_hit_core_tb
// Self-checking bench for the nearest-hit ray intersection core. A queue of
// requests (directed corner cases, then rays followed by spheres, planes and
// disks placed along them, plus random noise) feeds a clocked driver. Each
// accepted request runs through a bit-exact closest-hit predictor, and the
// monitor compares every result against the oldest prediction. The threshold
// register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module ray_nearest_hit_core_tb import rnh_pkg::*; ();

    typedef logic signed [127:0] wide_t;
    typedef logic signed [31:0]  coord_t;

    typedef struct {
        action_t    act;
        coord_t     px, py, pz;
        coord_t     vx, vy, vz;
        logic [30:0] rad;
    } ray_req_t;

    typedef struct {
        logic        hit;
        logic [31:0] near_t;
        logic [7:0]  idx;
    } hit_res_t;

    localparam logic [31:0] NO_HIT    = 32'hFFFF_FFFF;
    localparam int          MAX_CYCLES = 800000;
    localparam int          DRAIN_WAIT = 150;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    coord_t      pos_x, pos_y, pos_z, vec_x, vec_y, vec_z;
    logic [30:0] radius;
    logic        out_valid;
    logic        out_stall;
    logic        hit_this;
    logic [31:0] nearest_distance;
    logic [7:0]  nearest_index;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    ray_req_t pending_reqs[$];
    hit_res_t expected_hits[$];
    int       errors;
    int       cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    logic     in_taken;

    coord_t      ray_org[3];
    coord_t      ray_dir[3];
    logic [31:0] best_t;
    logic [7:0]  best_obj;
    logic [7:0]  obj_count;
    logic [15:0] par_thr;

    ray_nearest_hit_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .radius(radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit_this(hit_this), .nearest_distance(nearest_distance),
        .nearest_index(nearest_index),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] int_sqrt(wide_t x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (({64'd0, trial} * {64'd0, trial}) <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic wide_t dot3(coord_t a[3], coord_t b[3]);
        return wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
             + wide_t'(a[2]) * wide_t'(b[2]);
    endfunction

    function automatic logic [31:0] sphere_dist(coord_t c[3], logic [30:0] r);
        wide_t h[3];
        wide_t lw, lt, dd, r2, t, hh;
        logic [63:0] l;
        for (int i = 0; i < 3; i++)
            h[i] = wide_t'(c[i]) - wide_t'(ray_org[i]);
        lw = h[0] * wide_t'(ray_dir[0]) + h[1] * wide_t'(ray_dir[1])
           + h[2] * wide_t'(ray_dir[2]);
        if (lw < 0)
            return NO_HIT;
        lt = lw >>> 16;
        if (lt > (wide_t'(1) <<< 33))
            return NO_HIT;
        hh = h[0] * h[0] + h[1] * h[1] + h[2] * h[2];
        dd = hh - lt * lt;
        r2 = wide_t'(r) * wide_t'(r);
        if (dd < 0 || dd > r2)
            return NO_HIT;
        l = int_sqrt(r2 - dd);
        t = (lt >= wide_t'(l)) ? lt - wide_t'(l) : lt + wide_t'(l);
        if (t >= wide_t'(64'hFFFF_FFFF))
            return NO_HIT;
        return t[31:0];
    endfunction

    function automatic logic [31:0] plane_dist(coord_t p[3], coord_t n[3], logic disk,
                                               logic [30:0] r);
        wide_t dp, num, q, v, sum;
        logic [63:0] nlen;
        dp = dot3(ray_dir, n);
        nlen = int_sqrt(dot3(n, n));
        if (dp <= wide_t'(par_thr) * wide_t'(nlen))
            return NO_HIT;
        if (dp == 0)
            return NO_HIT;
        num = (wide_t'(p[0]) - wide_t'(ray_org[0])) * wide_t'(n[0])
            + (wide_t'(p[1]) - wide_t'(ray_org[1])) * wide_t'(n[1])
            + (wide_t'(p[2]) - wide_t'(ray_org[2])) * wide_t'(n[2]);
        if (num < 0)
            return NO_HIT;
        q = (num <<< 16) / dp;
        if (q >= wide_t'(64'hFFFF_FFFF))
            return NO_HIT;
        if (!disk)
            return q[31:0];
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            v = wide_t'(ray_org[i]) - wide_t'(p[i]) + ((wide_t'(ray_dir[i]) * q) >>> 16);
            if (v < 0)
                v = -v;
            if (v > (wide_t'(1) <<< 32))
                return NO_HIT;
            sum = sum + v * v;
        end
        if (sum > wide_t'(r) * wide_t'(r))
            return NO_HIT;
        return q[31:0];
    endfunction

    function automatic hit_res_t trace_step(ray_req_t rq);
        hit_res_t    res;
        coord_t      p[3];
        coord_t      v[3];
        logic [31:0] t;
        p = '{rq.px, rq.py, rq.pz};
        v = '{rq.vx, rq.vy, rq.vz};
        res.hit = 1'b0;
        if (rq.act == ACT_START)
        begin
            ray_org = p;
            ray_dir = v;
            best_t = NO_HIT;
            best_obj = '0;
            obj_count = '0;
        end
        else
        begin
            if (rq.act == ACT_SPHERE)
                t = sphere_dist(p, rq.rad);
            else
                t = plane_dist(p, v, rq.act == ACT_DISK, rq.rad);
            if (t < best_t)
            begin
                best_t = t;
                best_obj = obj_count;
                res.hit = 1'b1;
            end
            obj_count = obj_count + 8'd1;
        end
        res.near_t = best_t;
        res.idx = best_obj;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                ray_req_t rq;
                rq = pending_reqs.pop_front();
                in_valid <= 1'b1;
                action <= rq.act;
                pos_x <= rq.px;
                pos_y <= rq.py;
                pos_z <= rq.pz;
                vec_x <= rq.vx;
                vec_y <= rq.vy;
                vec_z <= rq.vz;
                radius <= rq.rad;
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (cycles > MAX_CYCLES)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            in_taken = in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
                par_thr = cfg_data;
            if (in_taken)
            begin
                ray_req_t rq;
                rq.act = action_t'(action);
                rq.px = pos_x;
                rq.py = pos_y;
                rq.pz = pos_z;
                rq.vx = vec_x;
                rq.vy = vec_y;
                rq.vz = vec_z;
                rq.rad = radius;
                expected_hits.insert(expected_hits.size(), trace_step(rq));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                else
                begin
                    hit_res_t want;
                    want = expected_hits.pop_front();
                    if (hit_this !== want.hit)
                        report_mismatch("hit_this", 32'(hit_this), 32'(want.hit));
                    if (nearest_distance !== want.near_t)
                        report_mismatch("nearest_distance", nearest_distance, want.near_t);
                    if (nearest_index !== want.idx)
                        report_mismatch("nearest_index", 32'(nearest_index), 32'(want.idx));
                end
            end
        end
    end

    function automatic coord_t rand_coord();
        return coord_t'($urandom());
    endfunction

    function automatic ray_req_t make_req(action_t a, coord_t px, coord_t py, coord_t pz,
                                          coord_t vx, coord_t vy, coord_t vz,
                                          logic [30:0] r);
        ray_req_t rq;
        rq.act = a;
        rq.px = px;
        rq.py = py;
        rq.pz = pz;
        rq.vx = vx;
        rq.vy = vy;
        rq.vz = vz;
        rq.rad = r;
        return rq;
    endfunction

    task automatic queue_req(ray_req_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    coord_t cur_org[3];
    coord_t cur_dir[3];

    task automatic push_ray();
        int axis;
        axis = $urandom_range(2);
        for (int i = 0; i < 3; i++)
        begin
            cur_org[i] = coord_t'($urandom_range(2097152)) - 32'sd1048576;
            cur_dir[i] = coord_t'($urandom_range(8192)) - 32'sd4096;
        end
        cur_dir[axis] = $urandom_range(1) ? 32'sd65536 : -32'sd65536;
        queue_req(make_req(ACT_START, cur_org[0], cur_org[1], cur_org[2],
                           cur_dir[0], cur_dir[1], cur_dir[2],
                           31'($urandom())));
    endtask

    task automatic push_prim();
        coord_t c[3];
        coord_t n[3];
        longint depth;
        action_t a;
        logic [30:0] r;
        a = action_t'($urandom_range(1, 3));
        depth = longint'($urandom_range(6553600)) - 65536;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = cur_org[i] + coord_t'((longint'(cur_dir[i]) * depth) >>> 16)
                 + coord_t'($urandom_range(262144)) - 32'sd131072;
            n[i] = cur_dir[i] + coord_t'($urandom_range(32768)) - 32'sd16384;
        end
        if ($urandom_range(9) == 0)
            n = '{-n[0], -n[1], -n[2]};
        r = 31'($urandom_range(1310720));
        if ($urandom_range(19) == 0)
            queue_req(make_req(action_t'($urandom_range(3)), rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(),
                               rand_coord(), rand_coord(), 31'($urandom())));
        else
            queue_req(make_req(a, c[0], c[1], c[2], n[0], n[1], n[2], r));
    endtask

    task automatic push_random(int count);
        int left;
        left = count;
        while (left > 0)
        begin
            int prims;
            push_ray();
            prims = ($urandom_range(15) == 0) ? 300 : $urandom_range(1, 12);
            for (int k = 0; k < prims && left > 0; k++)
            begin
                push_prim();
                left--;
            end
            left--;
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_hits.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_taken = 1'b0;
        action = ACT_START;
        {pos_x, pos_y, pos_z, vec_x, vec_y, vec_z} = '0;
        radius = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 0};
        best_t = NO_HIT;
        best_obj = '0;
        obj_count = '0;
        par_thr = '0;
        send_idle_pct = 14;
        recv_idle_pct = 69;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sphere before any ray start, then corner cases
        queue_req(make_req(ACT_SPHERE, 32'sd65536, 0, 0, 0, 0, 0, 31'd131072));
        queue_req(make_req(ACT_START, 0, 0, 0, 32'sd65536, 0, 0, '1));
        queue_req(make_req(ACT_SPHERE, 32'sd655360, 0, 0, 0, 0, 0, 31'd65536));
        queue_req(make_req(ACT_SPHERE, 32'sd655360, 0, 0, 0, 0, 0, 31'd65536));
        queue_req(make_req(ACT_SPHERE, -32'sd655360, 0, 0, 0, 0, 0, 31'd131072));
        queue_req(make_req(ACT_SPHERE, 32'sd65536, 0, 0, 0, 0, 0, 31'd131072));
        queue_req(make_req(ACT_PLANE, 32'sd327680, 0, 0, 32'sd65536, 0, 0, 0));
        queue_req(make_req(ACT_PLANE, 32'sd32768, 0, 0, 0, 0, 0, 0));
        queue_req(make_req(ACT_PLANE, 32'sd32768, 0, 0, -32'sd65536, 0, 0, 0));
        queue_req(make_req(ACT_DISK, 32'sd196608, 32'sd16384, 0,
                           32'sd65536, 0, 0, 31'd32768));
        queue_req(make_req(ACT_DISK, 32'sd131072, 32'sd16384, 0,
                           32'sd65536, 0, 0, 31'd8192));
        queue_req(make_req(ACT_SPHERE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 0, 0, 0, '1));
        queue_req(make_req(ACT_PLANE, 32'sh7FFF_FFFF, 0, 0,
                           32'sd1, 0, 0, 0));
        queue_req(make_req(ACT_START, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 0));
        queue_req(make_req(ACT_SPHERE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 0, 0, 0, '1));
        queue_req(make_req(ACT_DISK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, '1));
        queue_req(make_req(ACT_START, 0, 0, 0, 32'sd131072, 0, 0, 0));
        queue_req(make_req(ACT_PLANE, 32'sd655360, 0, 0, 32'sd65536, 0, 0, 0));
        queue_req(make_req(ACT_SPHERE, 32'sd327680, 0, 0, 0, 0, 0, 31'd65536));
        wait_drained();

        write_threshold(16'hFFFF);
        push_random(150);
        wait_drained();

        write_threshold(16'd0);
        push_random(200);
        // hold the sender until everything in flight has come back
        wait_drained();
        push_random(100);
        wait_drained();

        send_idle_pct = 69;
        recv_idle_pct = 14;
        write_threshold(16'($urandom_range(1, 2000)));
        push_random(250);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'($urandom()));
        push_random(80);
        wait_drained();
        write_threshold(16'd0);
        push_random(170);
        wait_drained();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rnh_pkg.sv
rtl/rnh_sqrt.sv
rtl/ray_nearest_hit_core.sv
tb/sv/ray_nearest_hit_core_tb.sv
